// ===== rtl/srtf_scheduler_tick_top_defines.svh =====
// ----------------------------------------------------------------------------
// SRTF scheduler assertion macros
// Shared concurrent property macros for the scheduler's port checker.
// ----------------------------------------------------------------------------
`ifndef SRTF_SCHEDULER_TICK_TOP_DEFINES_SVH
`define SRTF_SCHEDULER_TICK_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle during reset
`define SRTF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srtf check failed");

// Next-cycle implication, sampled on clk_i, idle during reset
`define SRTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srtf check failed");

`endif

// ===== rtl/srtf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Field widths and the scan word passed along the cell chain.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int unsigned FieldW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PidW   = 5;

  localparam logic [TimeW-1:0] TimeMax = '1;

  // Input word kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindTick = 1'b1;

  // Running best candidate handed from cell to cell
  typedef struct packed {
    logic              found;    // a ready process has been seen
    logic              pending;  // some loaded process still has work
    logic [FieldW-1:0] rem;      // remaining time of the best so far
  } scan_t;

endpackage

// ===== rtl/srtf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF process cell
// Holds one process slot and folds it into the running best candidate.
// ----------------------------------------------------------------------------
module srtf_cell #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned IDX       = 0,
  localparam int unsigned IdxW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int unsigned CntW     = $clog2(MAX_PROCS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [srtf_pkg::TimeW-1:0]    time_i,
  input  logic [CntW-1:0]               count_i,
  input  logic                          wr_i,
  input  logic [srtf_pkg::FieldW-1:0]   wr_arr_i,
  input  logic [srtf_pkg::FieldW-1:0]   wr_burst_i,
  input  logic                          dec_i,
  input  logic [IdxW-1:0]               dec_idx_i,
  input  srtf_pkg::scan_t               scan_i,
  input  logic [IdxW-1:0]               idx_i,
  output srtf_pkg::scan_t               scan_o,
  output logic [IdxW-1:0]               idx_o
);

  logic [srtf_pkg::FieldW-1:0] arr_q, arr_d;
  logic [srtf_pkg::FieldW-1:0] rem_q, rem_d;
  srtf_pkg::scan_t             scan_q, scan_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic                        loaded, busy, ready, take;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);
  localparam logic [CntW-1:0] MyCnt = CntW'(IDX);

  // Slot occupancy and eligibility
  assign loaded = MyCnt < count_i;
  assign busy   = loaded && (rem_q != '0);
  assign ready  = busy && ({{(srtf_pkg::TimeW-srtf_pkg::FieldW){1'b0}}, arr_q} <= time_i);
  // strict compare keeps the lower slot on a tie
  assign take   = ready && (!scan_i.found || (rem_q < scan_i.rem));

  // Slot write and one-unit decrement
  always_comb begin
    arr_d = arr_q;
    rem_d = rem_q;
    if (wr_i && (count_i == MyCnt)) begin
      arr_d = wr_arr_i;
      rem_d = wr_burst_i;
    end else if (dec_i && (dec_idx_i == MyIdx)) begin
      rem_d = rem_q - srtf_pkg::FieldW'(1);
    end
  end

  // Candidate merge
  always_comb begin
    scan_d         = scan_i;
    idx_d          = idx_i;
    scan_d.pending = scan_i.pending || busy;
    if (take) begin
      scan_d.found = 1'b1;
      scan_d.rem   = rem_q;
      idx_d        = MyIdx;
    end
  end

  always_ff @(posedge clk_i) begin
    arr_q <= arr_d;
    rem_q <= rem_d;
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;
  assign idx_o  = idx_q;

endmodule

// ===== rtl/srtf_scheduler_tick_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF scheduler, tick level
// Shortest-remaining-time-first scheduler built as a chain of process cells.
// ----------------------------------------------------------------------------
//  channel | direction | words
//  --------+-----------+-------------------------------------------
//  in      | sink      | kind, arrival_time, burst_time
//  out     | source    | slot_time, process_id, completed, all_done
//
//  A load word is taken while idle and gives no output word.
//  A tick word is taken in S_IDLE, then in S_SCAN the best candidate
//  ripples through the registered cell chain, and S_FIN commits and
//  registers the result.
//  One word is worked on at a time; loads are still taken while an output
//  word waits. A stalled output holds the commit step until it is taken.
//  Reset clears the fill count, the time counter and the handshake state.
// ----------------------------------------------------------------------------
module srtf_scheduler_tick_top #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic [srtf_pkg::FieldW-1:0]       arrival_time_i,
  input  logic [srtf_pkg::FieldW-1:0]       burst_time_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [srtf_pkg::TimeW-1:0]        slot_time_o,
  output logic [srtf_pkg::PidW-1:0]         process_id_o,
  output logic                              completed_o,
  output logic                              all_done_o
);

  localparam int unsigned IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);
  localparam logic [CntW-1:0] CntMax  = CntW'(MAX_PROCS);
  localparam logic [CntW-1:0] ScanEnd = CntW'(MAX_PROCS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e                        state_q;
  logic [CntW-1:0]               count_q, count_d;
  logic [CntW-1:0]               scan_cnt_q;
  logic [srtf_pkg::TimeW-1:0]    time_q, time_d;
  logic                          out_valid_q;
  logic [srtf_pkg::TimeW-1:0]    slot_time_q;
  logic [srtf_pkg::PidW-1:0]     process_id_q;
  logic                          completed_q;
  logic                          all_done_q;

  srtf_pkg::scan_t               scan_w [MAX_PROCS+1];
  logic [IdxW-1:0]               idx_w  [MAX_PROCS+1];

  logic                          in_fire, load_fire, tick_fire, fin_fire, wr_en;
  srtf_pkg::scan_t               best;
  logic [IdxW-1:0]               best_idx;
  logic [IdxW:0]                 best_id;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && (kind_i == srtf_pkg::KindLoad);
  assign tick_fire  = in_fire && (kind_i == srtf_pkg::KindTick);
  assign wr_en      = load_fire && (count_q != CntMax);
  assign fin_fire   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  assign best     = scan_w[MAX_PROCS];
  assign best_idx = idx_w[MAX_PROCS];
  assign best_id  = {1'b0, best_idx} + (IdxW+1)'(1);

  // Cell chain
  assign scan_w[0] = '0;
  assign idx_w[0]  = '0;

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    srtf_cell #(
      .MAX_PROCS (MAX_PROCS),
      .IDX       (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .time_i     (time_q),
      .count_i    (count_q),
      .wr_i       (wr_en),
      .wr_arr_i   (arrival_time_i),
      .wr_burst_i (burst_time_i),
      .dec_i      (fin_fire && best.found),
      .dec_idx_i  (best_idx),
      .scan_i     (scan_w[g]),
      .idx_i      (idx_w[g]),
      .scan_o     (scan_w[g+1]),
      .idx_o      (idx_w[g+1])
    );
  end

  // Fill count and time counter
  always_comb begin
    count_d = count_q;
    time_d  = time_q;
    if (wr_en) begin
      count_d = count_q + CntW'(1);
    end
    if (fin_fire && (best.found || best.pending) && (time_q != srtf_pkg::TimeMax)) begin
      time_d = time_q + srtf_pkg::TimeW'(1);
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      count_q     <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      time_q  <= time_d;
      // output word: raised on commit, dropped once taken
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (tick_fire) begin
            state_q    <= S_SCAN;
            scan_cnt_q <= '0;
          end
        end
        S_SCAN: begin
          scan_cnt_q <= scan_cnt_q + CntW'(1);
          if (scan_cnt_q == ScanEnd) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      slot_time_q  <= time_q;
      process_id_q <= best.found ? srtf_pkg::PidW'(best_id) : '0;
      completed_q  <= best.found && (best.rem == srtf_pkg::FieldW'(1));
      all_done_q   <= !best.found && !best.pending;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slot_time_o  = slot_time_q;
  assign process_id_o = process_id_q;
  assign completed_o  = completed_q;
  assign all_done_o   = all_done_q;

endmodule

// ===== rtl/srtf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF scheduler port checker
// Watches the top level's ports for output word consistency over time.
// ----------------------------------------------------------------------------
`include "srtf_scheduler_tick_top_defines.svh"

module srtf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] slot_time_o,
  input logic [4:0]  process_id_o,
  input logic        completed_o,
  input logic        all_done_o
);

  // stalled output word stays offered with its slot time unchanged
  `SRTF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `SRTF_ASSERT_NEXT(a_time_hold, out_valid_o && !out_ready_i, $stable(slot_time_o))

  // an all-done word names no process
  `SRTF_ASSERT_NOW(a_done_idle, out_valid_o && all_done_o, (process_id_o == 5'd0) && !completed_o)

  // completion is only reported for a real process
  `SRTF_ASSERT_NOW(a_cmp_pid, out_valid_o && completed_o, process_id_o != 5'd0)

endmodule

bind srtf_scheduler_tick_top srtf_checker u_srtf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .slot_time_o  (slot_time_o),
  .process_id_o (process_id_o),
  .completed_o  (completed_o),
  .all_done_o   (all_done_o)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SRTF scheduler tick testbench
// Drives load and tick words through the valid/ready input channel and checks
// every output word against a local scheduling predictor. A short directed
// table covers the corner cases, then random traffic runs under random
// stalls, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MaxProcs = 16;
  localparam int unsigned DirRows  = 18;
  localparam int unsigned RandWords = 900;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 40;
  localparam longint     LimitNs = 5_000_000;

  // One scheduled slot as reported by the block
  typedef struct packed {
    logic [srtf_pkg::TimeW-1:0] slot_time;
    logic [srtf_pkg::PidW-1:0]  process_id;
    logic                       completed;
    logic                       all_done;
  } slot_rec_t;

  // Directed stimulus row; typed rows carry their own expected slot
  typedef struct packed {
    logic                       kind;
    logic [srtf_pkg::FieldW-1:0] arrival;
    logic [srtf_pkg::FieldW-1:0] burst;
    logic                       typed;
    slot_rec_t                  want;
  } dir_row_t;

  localparam slot_rec_t NoRec = '0;

  // Corner cases: nothing loaded, zero burst, idle before arrival, tie on
  // remaining time, preemption by a shorter arrival, completion
  localparam dir_row_t DirTable [DirRows] = '{
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b1}},
    '{srtf_pkg::KindLoad, 16'hFFFF, 16'h0000, 1'b0, NoRec},
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b1}},
    '{srtf_pkg::KindLoad, 16'h0002, 16'h0001, 1'b0, NoRec},
    '{srtf_pkg::KindTick, 16'hFFFF, 16'hFFFF, 1'b1, '{32'd0, 5'd0, 1'b0, 1'b0}},
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b1, '{32'd1, 5'd0, 1'b0, 1'b0}},
    '{srtf_pkg::KindTick, 16'h5A5A, 16'hA5A5, 1'b1, '{32'd2, 5'd2, 1'b1, 1'b0}},
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b1, '{32'd3, 5'd0, 1'b0, 1'b1}},
    '{srtf_pkg::KindLoad, 16'h0000, 16'h0003, 1'b0, NoRec},
    '{srtf_pkg::KindLoad, 16'h0000, 16'h0003, 1'b0, NoRec},
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b1, '{32'd3, 5'd3, 1'b0, 1'b0}},
    '{srtf_pkg::KindLoad, 16'h0000, 16'h0001, 1'b0, NoRec},
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b1, '{32'd4, 5'd5, 1'b1, 1'b0}},
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b1, '{32'd5, 5'd3, 1'b0, 1'b0}},
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b1, '{32'd6, 5'd3, 1'b1, 1'b0}},
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b0, NoRec},
    '{srtf_pkg::KindLoad, 16'h0008, 16'h0001, 1'b0, NoRec},
    '{srtf_pkg::KindTick, 16'h0000, 16'h0000, 1'b0, NoRec}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        kind_i;
  logic [srtf_pkg::FieldW-1:0] arrival_time_i;
  logic [srtf_pkg::FieldW-1:0] burst_time_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [srtf_pkg::TimeW-1:0]  slot_time_o;
  logic [srtf_pkg::PidW-1:0]   process_id_o;
  logic                        completed_o;
  logic                        all_done_o;

  // Scheduler state as the predictor sees it
  logic [srtf_pkg::FieldW-1:0] arr_mem [MaxProcs];
  logic [srtf_pkg::FieldW-1:0] rem_mem [MaxProcs];
  int unsigned                 n_loaded;
  logic [srtf_pkg::TimeW-1:0]  now_t;

  slot_rec_t   slot_q [$];
  int unsigned errors;
  bit          calm;
  bit          hold_req;
  int unsigned ticks_sent, loads_sent, loads_dropped;
  int unsigned runs_seen, completions_seen, idles_seen, dones_seen;

  srtf_scheduler_tick_top #(
    .MAX_PROCS(MaxProcs)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .arrival_time_i(arrival_time_i),
    .burst_time_i  (burst_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slot_time_o   (slot_time_o),
    .process_id_o  (process_id_o),
    .completed_o   (completed_o),
    .all_done_o    (all_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(LimitNs);
    $display("CHECKS FAILED");
    $finish;
  end

  // Predictor: applies one word, returns 1 when a slot is reported
  function automatic bit schedule_word(input logic kind,
                                       input logic [srtf_pkg::FieldW-1:0] arrival,
                                       input logic [srtf_pkg::FieldW-1:0] burst,
                                       output slot_rec_t rec);
    int unsigned pick;
    logic [srtf_pkg::FieldW-1:0] pick_rem;
    bit found;
    bit pending;
    found = 1'b0;
    pending = 1'b0;
    pick = 0;
    pick_rem = '0;
    rec = '0;
    if (kind == srtf_pkg::KindLoad) begin
      if (n_loaded < MaxProcs) begin
        arr_mem[n_loaded] = arrival;
        rem_mem[n_loaded] = burst;
        n_loaded++;
      end else begin
        loads_dropped++;
      end
      return 1'b0;
    end
    // shortest remaining among arrived processes, lowest slot on a tie
    for (int unsigned i = 0; i < n_loaded; i++) begin
      if (rem_mem[i] != '0) begin
        pending = 1'b1;
        if (srtf_pkg::TimeW'(arr_mem[i]) <= now_t && (!found || rem_mem[i] < pick_rem)) begin
          found = 1'b1;
          pick = i;
          pick_rem = rem_mem[i];
        end
      end
    end
    rec.slot_time = now_t;
    if (found) begin
      rem_mem[pick] = pick_rem - 1'b1;
      rec.process_id = srtf_pkg::PidW'(pick + 1);
      rec.completed = (rem_mem[pick] == '0);
    end else if (!pending) begin
      rec.all_done = 1'b1;
      return 1'b1;
    end
    if (now_t != srtf_pkg::TimeMax) now_t++;
    return 1'b1;
  endfunction

  // Offer one word, hold it until taken, then log the expected slot
  task automatic offer_word(input logic kind, input logic [srtf_pkg::FieldW-1:0] arrival,
                            input logic [srtf_pkg::FieldW-1:0] burst, input logic typed,
                            input slot_rec_t want);
    slot_rec_t rec;
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    arrival_time_i <= arrival;
    burst_time_i   <= burst;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    if (kind == srtf_pkg::KindTick) ticks_sent++;
    else loads_sent++;
    if (schedule_word(kind, arrival, burst, rec)) begin
      if (typed) rec = want;
      slot_q.insert(slot_q.size(), rec);
    end
  endtask

  // Output side: check each taken word, then pick next ready
  initial begin
    int unsigned hold_left;
    slot_rec_t exp_rec;
    hold_left = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (slot_q.size() == 0) begin
          $error("unexpected output word: slot_time %0d process_id %0d", slot_time_o,
                 process_id_o);
          errors++;
        end else begin
          exp_rec = slot_q.pop_front();
          if (slot_time_o !== exp_rec.slot_time) begin
            $error("slot_time: expected %0d, got %0d", exp_rec.slot_time, slot_time_o);
            errors++;
          end
          if (process_id_o !== exp_rec.process_id) begin
            $error("process_id: expected %0d, got %0d", exp_rec.process_id, process_id_o);
            errors++;
          end
          if (completed_o !== exp_rec.completed) begin
            $error("completed: expected %0d, got %0d", exp_rec.completed, completed_o);
            errors++;
          end
          if (all_done_o !== exp_rec.all_done) begin
            $error("all_done: expected %0d, got %0d", exp_rec.all_done, all_done_o);
            errors++;
          end
          if (exp_rec.process_id != '0) runs_seen++;
          if (exp_rec.completed) completions_seen++;
          if (exp_rec.all_done) dones_seen++;
          else if (exp_rec.process_id == '0) idles_seen++;
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // Input side and run control
  initial begin
    logic [srtf_pkg::FieldW-1:0] arrival;
    logic [srtf_pkg::FieldW-1:0] burst;
    longint                      arr_wide;
    errors = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    n_loaded = 0;
    now_t = '0;
    ticks_sent = 0;
    loads_sent = 0;
    loads_dropped = 0;
    runs_seen = 0;
    completions_seen = 0;
    idles_seen = 0;
    dones_seen = 0;
    for (int unsigned i = 0; i < MaxProcs; i++) begin
      arr_mem[i] = '0;
      rem_mem[i] = '0;
    end
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    kind_i         <= srtf_pkg::KindLoad;
    arrival_time_i <= '0;
    burst_time_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int unsigned r = 0; r < DirRows; r++) begin
      offer_word(DirTable[r].kind, DirTable[r].arrival, DirTable[r].burst,
                 DirTable[r].typed, DirTable[r].want);
    end

    // random traffic: sparse loads arriving near the current time, mostly ticks
    for (int unsigned i = 0; i < RandWords; i++) begin
      if (i == 250) hold_req = 1'b1;
      if (i == 500) begin
        // drain pause: wait for every outstanding slot
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (slot_q.size() != 0);
      end
      calm = (i >= 600 && i < 700);
      if (n_loaded < MaxProcs && $urandom_range(0, 29) == 0) begin
        arr_wide = longint'(now_t) + $urandom_range(0, 40);
        arrival = (arr_wide > 65535) ? 16'hFFFF : srtf_pkg::FieldW'(arr_wide);
        burst = ($urandom_range(0, 9) == 0) ? 16'h0000 :
                srtf_pkg::FieldW'($urandom_range(1, 50));
        offer_word(srtf_pkg::KindLoad, arrival, burst, 1'b0, NoRec);
      end else if (n_loaded == MaxProcs && $urandom_range(0, 24) == 0) begin
        // past capacity: full-range values, dropped by the block
        offer_word(srtf_pkg::KindLoad, srtf_pkg::FieldW'($urandom_range(0, 65535)),
                   srtf_pkg::FieldW'($urandom_range(0, 65535)), 1'b0, NoRec);
      end else begin
        offer_word(srtf_pkg::KindTick, srtf_pkg::FieldW'($urandom_range(0, 65535)),
                   srtf_pkg::FieldW'($urandom_range(0, 65535)), 1'b0, NoRec);
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (slot_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d ticks and %0d load words (%0d stored, %0d dropped past capacity).",
             ticks_sent, loads_sent, n_loaded, loads_dropped);
    $display("Slots seen: %0d runs, %0d completions, %0d idle, %0d all-done.",
             runs_seen, completions_seen, idles_seen, dones_seen);
    if (errors == 0 && slot_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/srtf_pkg.sv
rtl/srtf_cell.sv
rtl/srtf_scheduler_tick_top.sv
rtl/srtf_checker.sv
test/testbench.sv
